// File: rtl/pzc_pkg.sv
// Package with request and result types, constants and tables for the POSTNET zip codec.
`timescale 1ns / 1ps

package pzc_pkg;

    localparam int ZIP_W          = 17;
    localparam int BAR_W          = 27;
    localparam int NUM_DIGITS_DEF = 5;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic [13:0] DIV10_MUL   = 14'd13107;
    localparam int          DIV10_SHIFT = 17;

    typedef struct packed {
        logic             operation;
        logic [ZIP_W-1:0] zip_value;
        logic [BAR_W-1:0] bar_code;
    } t_req;

    typedef struct packed {
        logic [ZIP_W-1:0] zip_out;
        logic [BAR_W-1:0] bars_out;
        logic             frame_error;
        logic             group_error;
    } t_rsp;

    function automatic logic [4:0] f_digit_bars(input logic [3:0] digit);
        logic [4:0] bars;
        unique case (digit)
            4'd0:    bars = 5'b11000;
            4'd1:    bars = 5'b00011;
            4'd2:    bars = 5'b00101;
            4'd3:    bars = 5'b00110;
            4'd4:    bars = 5'b01001;
            4'd5:    bars = 5'b01010;
            4'd6:    bars = 5'b01100;
            4'd7:    bars = 5'b10001;
            4'd8:    bars = 5'b10010;
            4'd9:    bars = 5'b10100;
            default: bars = 5'b00000;
        endcase
        return bars;
    endfunction

    // Returns {invalid, digit} for one five-bar group, first bar in bit 4.
    function automatic logic [4:0] f_group_digit(input logic [4:0] grp);
        logic [3:0] sum;
        logic [4:0] res;
        sum = (grp[4] ? 4'd7 : 4'd0) + (grp[3] ? 4'd4 : 4'd0)
            + (grp[2] ? 4'd2 : 4'd0) + (grp[1] ? 4'd1 : 4'd0);
        if (sum == 4'd11) begin
            res = 5'd0;
        end else if (sum >= 4'd1 && sum <= 4'd9) begin
            res = {1'b0, sum};
        end else begin
            res = 5'b10000;
        end
        return res;
    endfunction

    function automatic logic [ZIP_W-1:0] f_pow10_mod(input int n);
        logic [ZIP_W-1:0] p;
        p = ZIP_W'(1);
        for (int i = 0; i < n; i++) begin
            p = ZIP_W'(p * ZIP_W'(10));
        end
        return p;
    endfunction

endpackage

// File: rtl/postnet_zip_codec.sv
// Top level of the pipelined POSTNET zip code encoder and decoder.
`timescale 1ns / 1ps

// A request is taken whenever i_start is high and o_busy is low; o_busy is only high while
// and just after reset, so one request may enter in every cycle. Each request gives exactly
// one result on o_rsp, marked by o_done for a single cycle, once it has passed through one
// entry stage, one stage per decimal digit (a divide by ten when encoding, a group lookup
// and multiply-accumulate when decoding) and one output stage. Results leave in request
// order and the receiver cannot hold them off.
module postnet_zip_codec
    import pzc_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    output logic o_busy,
    output logic o_done,
    output t_rsp o_rsp
);

    localparam int BC = 5 * NUM_DIGITS + 2;
    localparam int BW = (BC > BAR_W) ? BC : BAR_W;
    localparam logic [ZIP_W-1:0] POW_MOD = f_pow10_mod(NUM_DIGITS);

    logic                 r_busy;
    logic                 r_vld  [0:NUM_DIGITS];
    logic                 r_op   [0:NUM_DIGITS];
    logic [ZIP_W-1:0]     r_val  [0:NUM_DIGITS];
    logic [ZIP_W-1:0]     r_zip  [0:NUM_DIGITS];
    logic [BW-1:0]        r_bars [0:NUM_DIGITS];
    logic                 r_ferr [0:NUM_DIGITS];
    logic                 r_gerr [0:NUM_DIGITS];
    logic                 r_done;
    t_rsp                 r_rsp;

    logic [BW-1:0]        n_bars_in;
    logic [BW-1:0]        n_frame;
    logic [ZIP_W-1:0]     n_zip_enc;

    assign n_bars_in = BW'(i_req.bar_code);
    assign n_frame   = BW'(1) | (BW'(1) << (BC - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_vld[0] <= 1'b0;
        end else begin
            r_busy   <= 1'b0;
            r_vld[0] <= i_start && !r_busy;
        end
        r_op[0]   <= i_req.operation;
        r_zip[0]  <= i_req.zip_value;
        r_gerr[0] <= 1'b0;
        if (i_req.operation == OP_ENCODE) begin
            r_val[0]  <= i_req.zip_value;
            r_bars[0] <= n_frame;
            r_ferr[0] <= 1'b0;
        end else begin
            r_val[0]  <= '0;
            r_bars[0] <= n_bars_in;
            r_ferr[0] <= !n_bars_in[BC-1] || !n_bars_in[0];
        end
    end

    for (genvar k = 1; k <= NUM_DIGITS; k++) begin : g_stage
        logic [30:0]      n_prod;
        logic [13:0]      n_q0;
        logic [ZIP_W-1:0] n_t;
        logic [ZIP_W-1:0] n_r0;
        logic [ZIP_W-1:0] n_quot;
        logic [3:0]       n_rem;
        logic [4:0]       n_grp;
        logic [4:0]       n_gd;
        logic [ZIP_W-1:0] n_acc;

        assign n_prod = 31'(r_val[k-1]) * 31'(DIV10_MUL);
        assign n_q0   = n_prod[30:DIV10_SHIFT];
        assign n_t    = ZIP_W'({n_q0, 3'b000}) + ZIP_W'({n_q0, 1'b0});
        assign n_r0   = r_val[k-1] - n_t;

        always_comb begin
            if (n_r0 >= ZIP_W'(10)) begin
                n_quot = ZIP_W'(n_q0) + ZIP_W'(1);
                n_rem  = 4'(n_r0 - ZIP_W'(10));
            end else begin
                n_quot = ZIP_W'(n_q0);
                n_rem  = n_r0[3:0];
            end
        end

        assign n_grp = r_bars[k-1][BC-2-5*(k-1) -: 5];
        assign n_gd  = f_group_digit(n_grp);
        assign n_acc = ZIP_W'({r_val[k-1], 3'b000}) + ZIP_W'({r_val[k-1], 1'b0})
                     + ZIP_W'(n_gd[3:0]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= r_vld[k-1];
            end
            r_op[k]   <= r_op[k-1];
            r_zip[k]  <= r_zip[k-1];
            r_ferr[k] <= r_ferr[k-1];
            if (r_op[k-1] == OP_ENCODE) begin
                r_val[k]  <= n_quot;
                r_bars[k] <= r_bars[k-1] | (BW'(f_digit_bars(n_rem)) << (1 + 5 * (k - 1)));
                r_gerr[k] <= 1'b0;
            end else begin
                r_val[k]  <= n_acc;
                r_bars[k] <= r_bars[k-1];
                r_gerr[k] <= r_gerr[k-1] || n_gd[4];
            end
        end
    end

    assign n_zip_enc = r_zip[NUM_DIGITS] - ZIP_W'(r_val[NUM_DIGITS] * POW_MOD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vld[NUM_DIGITS];
        end
        r_rsp.bars_out    <= r_bars[NUM_DIGITS][BAR_W-1:0];
        r_rsp.frame_error <= r_ferr[NUM_DIGITS];
        r_rsp.group_error <= r_gerr[NUM_DIGITS];
        if (r_op[NUM_DIGITS] == OP_ENCODE) begin
            r_rsp.zip_out <= n_zip_enc;
        end else begin
            r_rsp.zip_out <= r_val[NUM_DIGITS];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// File: rtl/pzc_checker.sv
// Port-level checker for the POSTNET zip codec and its bind to the top level.
`timescale 1ns / 1ps

module pzc_checker
    import pzc_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input t_req i_req,
    input logic o_busy,
    input logic o_done,
    input t_rsp o_rsp
);

    localparam int LAT = NUM_DIGITS + 2;
    localparam int CW  = $clog2(LAT + 1);

    logic [CW-1:0] r_warm;
    logic          n_warm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm <= '0;
        end else if (r_warm != CW'(LAT)) begin
            r_warm <= r_warm + CW'(1);
        end
    end

    assign n_warm = (r_warm == CW'(LAT));

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LAT o_done)
        else $error("Accepted request gave no result at the expected latency.");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n || !n_warm)
        o_done |-> $past(i_start && !o_busy, LAT))
        else $error("Result strobe without a matching request.");

    a_encode_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n || !n_warm)
        (o_done && $past(i_req.operation == OP_ENCODE, LAT))
            |-> (!o_rsp.frame_error && !o_rsp.group_error))
        else $error("Error flag raised on an encode result.");

    a_decode_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n || !n_warm)
        (o_done && $past(i_req.operation == OP_DECODE, LAT))
            |-> (o_rsp.bars_out == $past(i_req.bar_code, LAT)))
        else $error("Decode result does not echo the request bars.");

endmodule

bind postnet_zip_codec pzc_checker #(
    .NUM_DIGITS(NUM_DIGITS)
) u_pzc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .i_req   (i_req),
    .o_busy  (o_busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);

// File: tb/tb_postnet_zip_codec.sv
// Self-checking testbench for the POSTNET zip codec: directed table, then randomised requests.
`timescale 1ns / 1ps

module tb_postnet_zip_codec;
    import pzc_pkg::*;

    localparam int          NUM_DIGITS  = NUM_DIGITS_DEF;
    localparam int          LATENCY     = NUM_DIGITS + 2;
    localparam int unsigned ZIP_MODULUS = 10 ** NUM_DIGITS;
    localparam int          RAND_ITEMS  = 360;

    typedef struct packed {
        t_req req;
        logic known;
        t_rsp rsp;
    } t_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    t_req i_req   = '0;
    logic o_busy;
    logic o_done;
    t_rsp o_rsp;

    logic row_known = 1'b0;
    t_rsp row_rsp   = '0;
    t_rsp pending_rsp[$];
    t_row directed_rows[$];
    int   n_errors  = 0;

    postnet_zip_codec i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_req  (i_req),
        .o_busy (o_busy),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [4:0] digit_pattern(input int unsigned digit);
        logic [4:0] pat;
        case (digit)
            0:       pat = 5'b11000;
            1:       pat = 5'b00011;
            2:       pat = 5'b00101;
            3:       pat = 5'b00110;
            4:       pat = 5'b01001;
            5:       pat = 5'b01010;
            6:       pat = 5'b01100;
            7:       pat = 5'b10001;
            8:       pat = 5'b10010;
            default: pat = 5'b10100;
        endcase
        return pat;
    endfunction

    function automatic t_rsp postnet_convert(input t_req req);
        t_rsp        rsp;
        int unsigned value;
        int unsigned sum;
        int unsigned digit;
        rsp = '0;
        if (req.operation == OP_ENCODE) begin
            value          = int'(req.zip_value) % ZIP_MODULUS;
            rsp.zip_out    = ZIP_W'(value);
            rsp.bars_out   = '0;
            rsp.bars_out[BAR_W-1] = 1'b1;
            rsp.bars_out[0]       = 1'b1;
            for (int g = NUM_DIGITS - 1; g >= 0; g--) begin
                rsp.bars_out[1 + 5 * (NUM_DIGITS - 1 - g) +: 5] = digit_pattern(value % 10);
                value = value / 10;
            end
        end else begin
            rsp.bars_out    = req.bar_code;
            rsp.frame_error = !(req.bar_code[BAR_W-1] && req.bar_code[0]);
            value           = 0;
            for (int g = 0; g < NUM_DIGITS; g++) begin
                sum = 0;
                for (int b = 0; b < 5; b++) begin
                    if (req.bar_code[BAR_W - 2 - 5 * g - b]) begin
                        case (b)
                            0:       sum += 7;
                            1:       sum += 4;
                            2:       sum += 2;
                            3:       sum += 1;
                            default: sum += 0;
                        endcase
                    end
                end
                if (sum == 11) begin
                    digit = 0;
                end else if (sum >= 1 && sum <= 9) begin
                    digit = sum;
                end else begin
                    digit           = 0;
                    rsp.group_error = 1'b1;
                end
                value = value * 10 + digit;
            end
            rsp.zip_out = ZIP_W'(value);
        end
        return rsp;
    endfunction

    function automatic logic [BAR_W-1:0] well_formed_bars();
        logic [BAR_W-1:0] bars;
        bars          = '0;
        bars[BAR_W-1] = 1'b1;
        bars[0]       = 1'b1;
        for (int g = 0; g < NUM_DIGITS; g++) begin
            bars[BAR_W - 2 - 5 * g -: 5] = digit_pattern($urandom_range(9));
        end
        return bars;
    endfunction

    function automatic t_req random_req();
        t_req        req;
        int unsigned pick;
        int unsigned grp;
        req.operation = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 75) begin
            req.zip_value = ZIP_W'($urandom_range(ZIP_MODULUS - 1));
        end else if (pick < 90) begin
            req.zip_value = ZIP_W'($urandom_range((1 << ZIP_W) - 1, ZIP_MODULUS));
        end else begin
            req.zip_value = ZIP_W'($urandom);
        end
        req.bar_code = well_formed_bars();
        pick = $urandom_range(99);
        if (pick >= 60 && pick < 75) begin
            grp = $urandom_range(NUM_DIGITS - 1);
            req.bar_code[BAR_W - 2 - 5 * grp -: 5] = 5'($urandom);
        end else if (pick >= 75 && pick < 85) begin
            if ($urandom_range(1) == 1) begin
                req.bar_code[BAR_W-1] = 1'b0;
            end else begin
                req.bar_code[0] = 1'b0;
            end
        end else if (pick >= 85) begin
            req.bar_code = BAR_W'($urandom);
        end
        return req;
    endfunction

    function automatic t_row make_row(input logic op, input logic [ZIP_W-1:0] zip,
                                      input logic [BAR_W-1:0] bars, input logic known,
                                      input t_rsp rsp);
        t_row row;
        row.req.operation = op;
        row.req.zip_value = zip;
        row.req.bar_code  = bars;
        row.known         = known;
        row.rsp           = rsp;
        return row;
    endfunction

    task automatic check_rsp(input t_rsp exp, input t_rsp act);
        if (act.zip_out !== exp.zip_out) begin
            $display("%0t: zip_out mismatch: expected %0d, actual %0d",
                     $time, exp.zip_out, act.zip_out);
            n_errors++;
        end
        if (act.bars_out !== exp.bars_out) begin
            $display("%0t: bars_out mismatch: expected %b, actual %b",
                     $time, exp.bars_out, act.bars_out);
            n_errors++;
        end
        if (act.frame_error !== exp.frame_error) begin
            $display("%0t: frame_error mismatch: expected %b, actual %b",
                     $time, exp.frame_error, act.frame_error);
            n_errors++;
        end
        if (act.group_error !== exp.group_error) begin
            $display("%0t: group_error mismatch: expected %b, actual %b",
                     $time, exp.group_error, act.group_error);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (o_done === 1'b1) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: result with no request waiting: expected none, actual %h",
                         $time, o_rsp);
                n_errors++;
            end else begin
                check_rsp(pending_rsp.pop_front(), o_rsp);
            end
        end
        if (i_start === 1'b1 && o_busy === 1'b0) begin
            pending_rsp.push_back(row_known ? row_rsp : postnet_convert(i_req));
        end
    end

    task automatic send_req(input t_row row, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            i_req   <= random_req();
            @(negedge i_clk);
        end
        i_start   <= 1'b1;
        i_req     <= row.req;
        row_known <= row.known;
        row_rsp   <= row.rsp;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        @(negedge i_clk);
    endtask

    initial begin
        t_row row;
        int   idle_pct;

        directed_rows.push_back(make_row(OP_ENCODE, 17'd0, '0, 1'b1,
            t_rsp'{17'd0, {1'b1, {5{5'b11000}}, 1'b1}, 1'b0, 1'b0}));
        directed_rows.push_back(make_row(OP_ENCODE, 17'd99999, '0, 1'b1,
            t_rsp'{17'd99999, {1'b1, {5{5'b10100}}, 1'b1}, 1'b0, 1'b0}));
        directed_rows.push_back(make_row(OP_ENCODE, '1, '0, 1'b0, '0));
        directed_rows.push_back(make_row(OP_ENCODE, 17'd100000, '1, 1'b0, '0));
        directed_rows.push_back(make_row(OP_ENCODE, 17'd12345, '1, 1'b0, '0));
        directed_rows.push_back(make_row(OP_ENCODE, 17'd1, '0, 1'b0, '0));
        directed_rows.push_back(make_row(OP_DECODE, 17'd0, '1, 1'b1,
            t_rsp'{17'd0, {BAR_W{1'b1}}, 1'b0, 1'b1}));
        directed_rows.push_back(make_row(OP_DECODE, 17'd0, '0, 1'b1,
            t_rsp'{17'd0, {BAR_W{1'b0}}, 1'b1, 1'b1}));
        directed_rows.push_back(make_row(OP_DECODE, '1,
            {1'b1, 5'b00011, 5'b00101, 5'b00110, 5'b01001, 5'b01010, 1'b1}, 1'b0, '0));
        directed_rows.push_back(make_row(OP_DECODE, 17'd0,
            {1'b0, 5'b10100, 5'b10010, 5'b10001, 5'b01100, 5'b11000, 1'b1}, 1'b0, '0));
        directed_rows.push_back(make_row(OP_DECODE, 17'd0,
            {1'b1, 5'b11000, 5'b00011, 5'b00101, 5'b00110, 5'b01001, 1'b0}, 1'b0, '0));
        directed_rows.push_back(make_row(OP_DECODE, 17'd0,
            {1'b1, 5'b00001, 5'b00011, 5'b00101, 5'b00110, 5'b01001, 1'b1}, 1'b0, '0));
        directed_rows.push_back(make_row(OP_DECODE, 17'd0,
            {1'b1, 5'b01010, 5'b10110, 5'b00101, 5'b00110, 5'b01001, 1'b1}, 1'b0, '0));
        directed_rows.push_back(make_row(OP_DECODE, 17'd0,
            {1'b1, 5'b01010, 5'b01100, 5'b11010, 5'b00110, 5'b01001, 1'b1}, 1'b0, '0));
        directed_rows.push_back(make_row(OP_DECODE, 17'd0,
            {1'b1, 5'b01010, 5'b01100, 5'b10001, 5'b11100, 5'b01001, 1'b1}, 1'b0, '0));
        directed_rows.push_back(make_row(OP_DECODE, 17'd0,
            {1'b1, 5'b01010, 5'b01100, 5'b10001, 5'b10010, 5'b11110, 1'b1}, 1'b0, '0));
        directed_rows.push_back(make_row(OP_DECODE, 17'd0,
            {1'b1, 5'b11001, 5'b00010, 5'b01111, 5'b10000, 5'b00111, 1'b1}, 1'b0, '0));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k]) begin
            send_req(directed_rows[k], 21);
        end

        // The sender idles now and then, then more often, and finally not at all.
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 21 : (phase == 1) ? 47 : 0;
            for (int n = 0; n < RAND_ITEMS; n++) begin
                row.req   = random_req();
                row.known = 1'b0;
                row.rsp   = '0;
                send_req(row, idle_pct);
            end
        end
        i_start <= 1'b0;

        while (pending_rsp.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2 * LATENCY) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
